/* design/rdps_pkg.sv */
package rdps_pkg;

	localparam int DEF_MAX_WIDTH = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int TW_N = 624;
	localparam int TW_M = 397;
	localparam int TW_IW = 10;
	localparam int FRAC_BITS = 51;
	localparam int GEO_W = 9;
	localparam int AMT_W = 11;
	localparam int TRIG_W = 16;
	localparam int COORD_W = 8;
	localparam int RGBA_W = 32;

	localparam logic [31:0] MT_MULT = 32'd1812433253;
	localparam logic [31:0] MT_MATRIX = 32'h9908B0DF;
	localparam logic [31:0] MT_TEMPER_B = 32'h9D2C5680;
	localparam logic [31:0] MT_TEMPER_C = 32'hEFC60000;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_AMOUNT = 3'd2,
		REG_COS    = 3'd3,
		REG_SIN    = 3'd4,
		REG_SEED   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_EMIT = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C,
		ST_GEN,
		ST_MUL1,
		ST_MUL2,
		ST_PLACE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		kind_t               kind;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic [RGBA_W-1:0]   rgba;
	} item_t;

	typedef struct packed {
		logic [GEO_W-1:0]         width;
		logic [GEO_W-1:0]         height;
		logic [AMT_W-1:0]         amount;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
		logic [31:0]              seed;
	} cfg_t;

	function automatic logic [31:0] tw_twist(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		logic [31:0] v;
		logic [31:0] w;
		v = {a[31], b[30:0]};
		w = c ^ (v >> 1);
		if (v[0]) begin
			w = w ^ MT_MATRIX;
		end
		return w;
	endfunction

	function automatic logic [31:0] tw_temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & MT_TEMPER_B);
		y = y ^ ((y << 15) & MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

/* design/random_directional_pixel_scatter.sv */
// A load request waits in the two-entry input queue; the idle back end writes it to the
// store. An emit runs ST_SEED at frame start (a reseed sweep of the twister memory),
// then two draws through a one-read-port memory (ST_RD_A, ST_RD_B, ST_RD_C, ST_GEN),
// ST_MUL1, ST_MUL2, ST_PLACE, ST_FETCH, ST_EMIT; zero amount skips draws and MULs.
// One load per cycle while idle; an emit holds off all requests; a held output stalls it.
// Reset: arst_n asynchronous active low; registers reset to defaults, queue emptied.
module random_directional_pixel_scatter import rdps_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // pixel_x, pixel_y, pixel_rgba
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // out_x, out_y, out_rgba
	output logic        m_tlast
);

	cfg_t     cfg_q;
	reg_idx_t ridx;
	logic     q_valid;
	item_t    q_item;
	logic     q_pop;

	assign pready = 1'b1;
	assign ridx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width <= GEO_W'(256);
			cfg_q.height <= GEO_W'(256);
			cfg_q.amount <= AMT_W'(480);
			cfg_q.cos_v <= 16'sd16384;
			cfg_q.sin_v <= 16'sd0;
			cfg_q.seed <= 32'd0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (ridx)
				REG_WIDTH: cfg_q.width <= pwdata[GEO_W-1:0];
				REG_HEIGHT: cfg_q.height <= pwdata[GEO_W-1:0];
				REG_AMOUNT: cfg_q.amount <= pwdata[AMT_W-1:0];
				REG_COS: cfg_q.cos_v <= $signed(pwdata[TRIG_W-1:0]);
				REG_SIN: cfg_q.sin_v <= $signed(pwdata[TRIG_W-1:0]);
				REG_SEED: cfg_q.seed <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (ridx)
			REG_WIDTH: prdata = 32'(cfg_q.width);
			REG_HEIGHT: prdata = 32'(cfg_q.height);
			REG_AMOUNT: prdata = 32'(cfg_q.amount);
			REG_COS: prdata = 32'(unsigned'(cfg_q.cos_v));
			REG_SIN: prdata = 32'(unsigned'(cfg_q.sin_v));
			REG_SEED: prdata = cfg_q.seed;
			default: prdata = '0;
		endcase
	end

	rdps_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	rdps_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

/* design/rdps_front.sv */
module rdps_front import rdps_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        s_tuser,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t      ent_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] cnt_q;
	item_t      in_item;
	logic       keep;
	logic       push;

	always_comb begin
		in_item.kind = kind_t'(s_tuser);
		in_item.x = s_tdata[7:0];
		in_item.y = s_tdata[15:8];
		in_item.rgba = s_tdata[47:16];
		keep = (in_item.kind == KIND_EMIT) ||
			((32'(in_item.x) < MAX_WIDTH) && (32'(in_item.y) < MAX_HEIGHT));
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

/* design/rdps_back.sv */
module rdps_back import rdps_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic        m_tlast
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_d;

	logic [RGBA_W-1:0] store [DEPTH];
	logic [RGBA_W-1:0] store_rd_q;
	logic [31:0]       tw_mem [TW_N];
	logic [31:0]       tw_rd_q;

	logic [TW_IW-1:0] idx_q;
	logic [TW_IW-1:0] idx_n1;
	logic [TW_IW-1:0] idx_nm;
	logic [TW_IW-1:0] seed_k_q;
	logic [31:0]      seed_p_q;
	logic [31:0]      a_q;
	logic [31:0]      b_q;
	logic [31:0]      lo_q;
	logic [31:0]      hi_q;
	logic             draw_hi_q;

	logic [GEO_W-1:0] col_q;
	logic [GEO_W-1:0] row_q;
	logic [GEO_W-1:0] emit_col_q;
	logic [GEO_W-1:0] emit_row_q;
	logic             last_q;

	logic signed [44:0] r_q;
	logic signed [60:0] dx_q;
	logic signed [60:0] dy_q;
	logic [GEO_W-1:0]   sx_q;
	logic [GEO_W-1:0]   sy_q;

	logic             out_vld_q;
	logic [47:0]      out_data_q;
	logic             out_last_q;

	logic [GEO_W-1:0] w_eff;
	logic [GEO_W-1:0] h_eff;
	logic             amt_zero;
	logic             take;
	logic             is_emit;
	logic             frame_start;

	logic [TW_IW-1:0] tw_raddr;
	logic             tw_we;
	logic [TW_IW-1:0] tw_waddr;
	logic [31:0]      tw_wdata;
	logic [31:0]      gen_word;
	logic [31:0]      gen_temp;
	logic [AW-1:0]    st_raddr;
	logic [AW-1:0]    st_waddr;
	logic             st_we;

	logic signed [32:0] offs;
	logic signed [63:0] sum_x;
	logic signed [63:0] sum_y;
	logic signed [63:0] cx;
	logic signed [63:0] cy;
	logic [GEO_W-1:0]   px;
	logic [GEO_W-1:0]   py;

	function automatic logic [GEO_W-1:0] clamp_geo(input logic [GEO_W-1:0] v, input int lim);
		logic [GEO_W-1:0] r;
		if (v == '0) begin
			r = GEO_W'(1);
		end else if (32'(v) > lim) begin
			r = GEO_W'(lim);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [GEO_W-1:0] place(input logic signed [63:0] c,
			input logic [GEO_W-1:0] lim);
		logic [GEO_W-1:0] r;
		if (c < 0) begin
			r = '0;
		end else if (c > $signed({55'd0, lim - GEO_W'(1)})) begin
			r = lim - GEO_W'(1);
		end else begin
			r = c[GEO_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		w_eff = clamp_geo(cfg.width, MAX_WIDTH);
		h_eff = clamp_geo(cfg.height, MAX_HEIGHT);
		amt_zero = (cfg.amount == '0);
		is_emit = (q_item.kind == KIND_EMIT);
		frame_start = (emit_col_q == '0) && (emit_row_q == '0);
		idx_n1 = (idx_q == TW_IW'(TW_N - 1)) ? '0 : idx_q + TW_IW'(1);
		idx_nm = (idx_q >= TW_IW'(TW_N - TW_M)) ? idx_q - TW_IW'(TW_N - TW_M)
			: idx_q + TW_IW'(TW_M);
		gen_word = tw_twist(a_q, b_q, tw_rd_q);
		gen_temp = tw_temper(gen_word);
		offs = $signed({~hi_q[31], hi_q[30:0], lo_q[31]});
		sum_x = $signed(64'(col_q) << FRAC_BITS) + (amt_zero ? 64'sd0 : 64'(dx_q));
		sum_y = $signed(64'(row_q) << FRAC_BITS) + (amt_zero ? 64'sd0 : 64'(dy_q));
		cx = sum_x >>> FRAC_BITS;
		cy = sum_y >>> FRAC_BITS;
		px = place(cx, w_eff);
		py = place(cy, h_eff);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && is_emit) begin
					if (frame_start) begin
						state_d = ST_SEED;
					end else if (amt_zero) begin
						state_d = ST_PLACE;
					end else begin
						state_d = ST_RD_A;
					end
				end
			end
			ST_SEED: begin
				if (seed_k_q == TW_IW'(TW_N - 1)) begin
					state_d = amt_zero ? ST_PLACE : ST_RD_A;
				end
			end
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_RD_C;
			ST_RD_C: state_d = ST_GEN;
			ST_GEN: state_d = draw_hi_q ? ST_MUL1 : ST_RD_A;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_PLACE;
			ST_PLACE: state_d = ST_FETCH;
			ST_FETCH: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_vld_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		tw_raddr = idx_q;
		tw_we = 1'b0;
		tw_waddr = idx_q;
		tw_wdata = gen_word;
		st_we = 1'b0;
		take = 1'b0;
		st_waddr = AW'(32'(q_item.y) * MAX_WIDTH + 32'(q_item.x));
		st_raddr = AW'(32'(sy_q) * MAX_WIDTH + 32'(sx_q));
		unique case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
				take = q_valid && is_emit;
				st_we = q_valid && !is_emit;
			end
			ST_SEED: begin
				tw_we = 1'b1;
				tw_waddr = seed_k_q;
				tw_wdata = seed_p_q;
			end
			ST_RD_B: tw_raddr = idx_n1;
			ST_RD_C: tw_raddr = idx_nm;
			ST_GEN: tw_we = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tw_we) begin
			tw_mem[tw_waddr] <= tw_wdata;
		end
		tw_rd_q <= tw_mem[tw_raddr];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store[st_waddr] <= q_item.rgba;
		end
		store_rd_q <= store[st_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			seed_k_q <= '0;
			draw_hi_q <= 1'b0;
			emit_col_q <= '0;
			emit_row_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				seed_k_q <= '0;
				draw_hi_q <= 1'b0;
				if ({1'b0, emit_col_q} + 10'd1 >= {1'b0, w_eff}) begin
					emit_col_q <= '0;
					if ({1'b0, emit_row_q} + 10'd1 >= {1'b0, h_eff}) begin
						emit_row_q <= '0;
					end else begin
						emit_row_q <= emit_row_q + GEO_W'(1);
					end
				end else begin
					emit_col_q <= emit_col_q + GEO_W'(1);
				end
			end
			if (state_q == ST_SEED) begin
				seed_k_q <= seed_k_q + TW_IW'(1);
				if (seed_k_q == TW_IW'(TW_N - 1)) begin
					idx_q <= '0;
				end
			end
			if (state_q == ST_GEN) begin
				idx_q <= idx_n1;
				draw_hi_q <= 1'b1;
			end
			if (state_q == ST_EMIT && !out_vld_q) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_q <= emit_col_q;
			row_q <= emit_row_q;
			last_q <= ({1'b0, emit_col_q} + 10'd1 >= {1'b0, w_eff}) &&
				({1'b0, emit_row_q} + 10'd1 >= {1'b0, h_eff});
			seed_p_q <= cfg.seed;
		end
		if (state_q == ST_SEED) begin
			seed_p_q <= 32'(MT_MULT * (seed_p_q ^ (seed_p_q >> 30))) +
				32'(seed_k_q + TW_IW'(1));
		end
		if (state_q == ST_RD_B) begin
			a_q <= tw_rd_q;
		end
		if (state_q == ST_RD_C) begin
			b_q <= tw_rd_q;
		end
		if (state_q == ST_GEN) begin
			if (draw_hi_q) begin
				hi_q <= gen_temp;
			end else begin
				lo_q <= gen_temp;
			end
		end
		if (state_q == ST_MUL1) begin
			r_q <= 45'(offs * $signed({1'b0, cfg.amount}));
		end
		if (state_q == ST_MUL2) begin
			dx_q <= r_q * cfg.cos_v;
			dy_q <= r_q * cfg.sin_v;
		end
		if (state_q == ST_PLACE) begin
			sx_q <= px;
			sy_q <= py;
		end
		if (state_q == ST_EMIT && !out_vld_q) begin
			out_data_q <= {store_rd_q, row_q[COORD_W-1:0], col_q[COORD_W-1:0]};
			out_last_q <= last_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;

	a_seed_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEED |-> seed_k_q < TW_IW'(TW_N))
		else $error("seed counter out of range");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < TW_IW'(TW_N))
		else $error("twister index out of range");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !out_vld_q) |=> (out_vld_q && state_q == ST_IDLE))
		else $error("result not handed to output register");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GEN && !draw_hi_q) |=> state_q == ST_RD_A)
		else $error("second draw skipped");

endmodule
